@@ design/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/irpce_pkg.sv @@
// Shared types and constants of the infrared packed code expander.
// No dependencies; used by the bit engine, the top level and the checker.
package irpce_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE_TIME = 2'd0,
		KIND_BEGIN      = 2'd1,
		KIND_BYTE       = 2'd2
	} kind_t;

	localparam int BPI_W      = 3;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 3;
	localparam int TIME_IDX_W = 5;
	localparam int TIME_W     = 16;
	localparam int PAIR_CNT_W = 10;
	localparam int BYTE_BITS  = 8;
	localparam int BITS_LEFT_W = 4;
	localparam int DUR_W      = 15;
	localparam int SCALED_W   = 20;

	localparam logic [BPI_W-1:0] BPI_RESET = 3'd2;
	localparam logic [BPI_W-1:0] BPI_MIN   = 3'd1;
	localparam logic [BPI_W-1:0] BPI_MAX   = 3'd4;
	localparam logic [DUR_W-1:0] DURATION_MAX = 15'h7fff;

	typedef struct packed {
		kind_t                   kind;
		logic [TIME_IDX_W-1:0]   time_index;
		logic [TIME_W-1:0]       time_value;
		logic [PAIR_CNT_W-1:0]   pair_count;
		logic [BYTE_BITS-1:0]    code_byte;
	} in_item_t;

	typedef struct packed {
		logic [DUR_W-1:0] on_time_us;
		logic [DUR_W-1:0] off_time_us;
		logic             last;
	} out_item_t;

	// Lookup request from the bit engine to the timing table stage.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic             last;
	} irpce_req_t;

endpackage

@@ design/irpce_bit_engine.sv @@
// Bit engine: shifts a packed code byte out one bit per cycle unless held by
// the lookup stage; gathers pair indices, counts down pairs. Uses irpce_pkg.
module irpce_bit_engine #(
	parameter int MAX_PAIRS = 1023
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [irpce_pkg::BPI_W-1:0]        bits_per_index,
	input  logic                               begin_code,
	input  logic [irpce_pkg::PAIR_CNT_W-1:0]   pair_count,
	input  logic                               load_byte,
	input  logic [irpce_pkg::BYTE_BITS-1:0]    code_byte,
	input  logic                               req_ready,
	output irpce_pkg::irpce_req_t              req,
	output logic                               hold
);
	import irpce_pkg::*;

	localparam int PW = $clog2(MAX_PAIRS + 1);
	localparam logic [PW-1:0] PAIRS_MAX = PW'(MAX_PAIRS);

	logic [BYTE_BITS-1:0]   byte_q;
	logic [BITS_LEFT_W-1:0] bits_left_q;
	logic                   busy_q;
	logic [IDX_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PW-1:0]          pairs_q;

	logic [BPI_W-1:0] width;
	logic [IDX_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;
	logic             complete;
	logic             step;
	logic             issue;
	logic             finish;
	logic [PW-1:0]    pairs_step;
	logic [PW-1:0]    pairs_load;

	always_comb begin
		if (bits_per_index < BPI_MIN) begin
			width = BPI_MIN;
		end else if (bits_per_index > BPI_MAX) begin
			width = BPI_MAX;
		end else begin
			width = bits_per_index;
		end
	end

	assign acc_n    = {acc_q[IDX_W-2:0], byte_q[BYTE_BITS-1]};
	assign cnt_n    = cnt_q + CNT_W'(1);
	assign complete = cnt_n >= width;

	// A completed index may only advance when the lookup stage can take it.
	assign step  = busy_q && (pairs_q != '0) && (!complete || req_ready);
	assign issue = step && complete;

	assign finish = busy_q && ((pairs_q == '0) ||
		(step && ((bits_left_q == BITS_LEFT_W'(1)) ||
		(complete && (pairs_q == PW'(1))))));

	assign pairs_step = issue ? pairs_q - PW'(1) : pairs_q;
	assign pairs_load = (32'(pair_count) > MAX_PAIRS) ? PAIRS_MAX : PW'(pair_count);

	assign req.valid = issue;
	assign req.index = acc_n;
	assign req.last  = (pairs_q == PW'(1));
	assign hold      = busy_q && !finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
			busy_q      <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			pairs_q     <= '0;
		end else begin
			if (step) begin
				bits_left_q <= bits_left_q - BITS_LEFT_W'(1);
				acc_q       <= complete ? '0 : acc_n;
				cnt_q       <= complete ? '0 : cnt_n;
				pairs_q     <= pairs_step;
			end
			if (finish) begin
				busy_q <= 1'b0;
			end
			// A new transaction is only taken when hold is low, so it lands in the
			// cycle of the last step of the byte in progress and overrides that step.
			if (begin_code) begin
				pairs_q <= pairs_load;
				acc_q   <= '0;
				cnt_q   <= '0;
			end
			if (load_byte && (pairs_step != '0)) begin
				busy_q      <= 1'b1;
				bits_left_q <= BITS_LEFT_W'(BYTE_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_byte) begin
			byte_q <= code_byte;
		end else if (step) begin
			byte_q <= {byte_q[BYTE_BITS-2:0], 1'b0};
		end
	end

endmodule

@@ design/ir_packed_code_expander_core.sv @@
// Infrared packed code expander. The bit engine shifts a packed code byte
// out one bit per cycle while the lookup stage can take its indices, and
// stops early when the code's last pair ends inside the byte; the next
// transaction is taken in the cycle the byte's last bit is handled. Each
// completed index reads its on and off times from the timing memory through
// its two read ports into the read register and then the output register, one
// result per cycle while the output is not stalled. The timing memory holds
// no reset value: entries must be written before a code refers to them.
module ir_packed_code_expander_core #(
	parameter int TIME_ENTRIES = 32,
	parameter int MAX_PAIRS    = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [irpce_pkg::BPI_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  irpce_pkg::in_item_t          in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output irpce_pkg::out_item_t         out_data
);
	import irpce_pkg::*;

	localparam int AW = (TIME_ENTRIES > 1) ? $clog2(TIME_ENTRIES) : 1;
	localparam int ADDR_SPAN = 2 ** (IDX_W + 1);

	typedef logic [AW-1:0] wrap_tab_t [ADDR_SPAN];

	// Pair addresses wrap around the table; worked out at elaboration.
	function automatic wrap_tab_t build_wrap();
		wrap_tab_t t;
		for (int i = 0; i < ADDR_SPAN; i++) begin
			t[i] = AW'(i % TIME_ENTRIES);
		end
		return t;
	endfunction

	localparam wrap_tab_t WRAP_ADDR = build_wrap();

	function automatic logic [DUR_W-1:0] scale_time(input logic [TIME_W-1:0] v);
		logic [SCALED_W-1:0] s;
		s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
		return (s > SCALED_W'(DURATION_MAX)) ? DURATION_MAX : s[DUR_W-1:0];
	endfunction

	logic [TIME_W-1:0] mem [TIME_ENTRIES];

	logic [BPI_W-1:0]  bpi_q;
	logic              in_accept;
	logic              begin_code;
	logic              load_byte;
	logic              write_time;
	logic              hold;
	irpce_req_t        req;
	logic              can_s1;
	logic              can_s2;

	logic              valid_s1;
	logic              last_s1;
	logic [TIME_W-1:0] on_raw_s1;
	logic [TIME_W-1:0] off_raw_s1;
	logic              valid_s2;
	out_item_t         data_s2;

	assign in_stall  = hold;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		begin_code = 1'b0;
		load_byte  = 1'b0;
		write_time = 1'b0;
		unique case (in_data.kind)
			KIND_WRITE_TIME: write_time = in_accept &&
				(32'(in_data.time_index) < TIME_ENTRIES);
			KIND_BEGIN:      begin_code = in_accept;
			KIND_BYTE:       load_byte  = in_accept;
			default:         ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpi_q <= BPI_RESET;
		end else if (cfg_we) begin
			bpi_q <= cfg_wdata;
		end
	end

	irpce_bit_engine #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.bits_per_index (bpi_q),
		.begin_code     (begin_code),
		.pair_count     (in_data.pair_count),
		.load_byte      (load_byte),
		.code_byte      (in_data.code_byte),
		.req_ready      (can_s1),
		.req            (req),
		.hold           (hold)
	);

	assign can_s2 = !valid_s2 || !out_stall;
	assign can_s1 = !valid_s1 || can_s2;

	// A write and a read of the same entry at one edge return the old value,
	// which matches the order of the transactions.
	always_ff @(posedge clk) begin
		if (write_time) begin
			mem[AW'(in_data.time_index)] <= in_data.time_value;
		end
		if (req.valid) begin
			on_raw_s1  <= mem[WRAP_ADDR[{req.index, 1'b0}]];
			off_raw_s1 <= mem[WRAP_ADDR[{req.index, 1'b1}]];
			last_s1    <= req.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid) begin
				valid_s1 <= 1'b1;
			end else if (can_s2) begin
				valid_s1 <= 1'b0;
			end
			if (can_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_s2 && valid_s1) begin
			data_s2.on_time_us  <= scale_time(on_raw_s1);
			data_s2.off_time_us <= scale_time(off_raw_s1);
			data_s2.last        <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

@@ design/irpce_checker.sv @@
// Port-level checker for the infrared packed code expander, bound to the top.
// Depends on irpce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irpce_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input irpce_pkg::in_item_t          in_data,
	input logic                         out_valid,
	input logic                         out_stall,
	input irpce_pkg::out_item_t         out_data
);
	import irpce_pkg::*;

	// Only a packed code byte can keep the input side busy.
	`ASSERT_CLK(a_stall_from_byte, $rose(in_stall) |-> $past(in_valid && !in_stall && in_data.kind == KIND_BYTE), "input stall rose without a byte transaction")

	// A timing write or a code begin never leaves the block busy.
	`ASSERT_CLK(a_no_stall_after_ctrl, (in_valid && !in_stall && in_data.kind != KIND_BYTE) |=> !in_stall, "stall after a non-byte transaction")

	// A stalled result holds.
	`ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")

	// No result straight out of reset.
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind ir_packed_code_expander_core irpce_checker u_irpce_checker (.*);
